FILE: rtl/core/rbsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray versus box slab test core.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	// One quotient bit is resolved in each divider stage.
	localparam int DIV_STAGES = 63;
	// Divider stages plus the sign stage.
	localparam int DIV_LAT    = DIV_STAGES + 1;

	localparam logic signed [63:0] SLAB_ALL_LOW  = 64'sh8000_0000_0000_0001;
	localparam logic signed [63:0] SLAB_ALL_HIGH = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [47:0] DIST_POS_LIMIT = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] DIST_NEG_LIMIT = 48'h8000_0000_0000;

	typedef enum logic [2:0] {
		REG_LOW_X  = 3'd0,
		REG_LOW_Y  = 3'd1,
		REG_LOW_Z  = 3'd2,
		REG_HIGH_X = 3'd3,
		REG_HIGH_Y = 3'd4,
		REG_HIGH_Z = 3'd5
	} reg_index_t;

	// Per-item control that travels beside the dividers.
	typedef struct packed {
		logic        vld;
		logic [30:0] len;
		logic [2:0]  dzero;
		logic [2:0]  in_span;
	} side_t;

endpackage

FILE: rtl/core/rbsi_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_divider
// Pipelined restoring divider, one quotient bit per stage, sign applied last.
// ----------------------------------------------------------------------------
module rbsi_divider import rbsi_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [62:0]        num,
	input  logic [31:0]        den,
	input  logic               neg,
	output logic signed [63:0] quot
);

	logic [31:0] rem_s [DIV_STAGES];
	logic [62:0] num_s [DIV_STAGES];
	logic [62:0] quo_s [DIV_STAGES];
	logic [31:0] den_s [DIV_STAGES];
	logic        neg_s [DIV_STAGES];

	logic [31:0] p_rem [DIV_STAGES];
	logic [62:0] p_num [DIV_STAGES];
	logic [62:0] p_quo [DIV_STAGES];
	logic [31:0] p_den [DIV_STAGES];
	logic        p_neg [DIV_STAGES];
	logic [31:0] n_rem [DIV_STAGES];
	logic        n_bit [DIV_STAGES];

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			logic [32:0] trial;
			logic [32:0] diff;
			if (k == 0) begin
				p_rem[k] = '0;
				p_num[k] = num;
				p_quo[k] = '0;
				p_den[k] = den;
				p_neg[k] = neg;
			end else begin
				p_rem[k] = rem_s[k-1];
				p_num[k] = num_s[k-1];
				p_quo[k] = quo_s[k-1];
				p_den[k] = den_s[k-1];
				p_neg[k] = neg_s[k-1];
			end
			trial = {p_rem[k], p_num[k][62]};
			diff  = trial - {1'b0, p_den[k]};
			n_bit[k] = (trial >= {1'b0, p_den[k]});
			n_rem[k] = n_bit[k] ? diff[31:0] : trial[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k] <= n_rem[k];
				num_s[k] <= {p_num[k][61:0], 1'b0};
				quo_s[k] <= {p_quo[k][61:0], n_bit[k]};
				den_s[k] <= p_den[k];
				neg_s[k] <= p_neg[k];
			end
			quot <= neg_s[DIV_STAGES-1] ? -$signed({1'b0, quo_s[DIV_STAGES-1]})
			                            : $signed({1'b0, quo_s[DIV_STAGES-1]});
		end
	end

endmodule

FILE: rtl/core/rbsi_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_scale
// Scales the entry magnitude by the ray length, saturates and signs it.
// ----------------------------------------------------------------------------
module rbsi_scale import rbsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  logic        hit_in,
	input  logic        neg_in,
	input  logic [63:0] mag_in,
	input  logic [30:0] len_in,
	output logic        vld,
	output logic        hit,
	output logic [47:0] distance
);

	logic        vld_s4, vld_s5;
	logic        hit_s4, hit_s5;
	logic        neg_s4, neg_s5;
	logic [62:0] plo_s4, phi_s4;
	logic [94:0] sum_s5;
	logic [78:0] scaled;
	logic [47:0] limit, mag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld    <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_in;
			vld_s5 <= vld_s4;
			vld    <= vld_s5;
		end
	end

	// Two's complement result: the negative limit is one step larger.
	assign scaled = sum_s5[94:16];
	assign limit  = neg_s5 ? DIST_NEG_LIMIT : DIST_POS_LIMIT;
	assign mag_d  = (scaled > {31'd0, limit}) ? limit : scaled[47:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= hit_in;
			neg_s4 <= neg_in;
			plo_s4 <= {32'd0, len_in} * {31'd0, mag_in[31:0]};
			phi_s4 <= {32'd0, len_in} * {31'd0, mag_in[63:32]};
			hit_s5 <= hit_s4;
			neg_s5 <= neg_s4;
			sum_s5 <= {phi_s4, 32'd0} + {32'd0, plo_s4};
			hit    <= hit_s5;
			distance <= !hit_s5 ? 48'd0 : (neg_s5 ? 48'd0 - mag_d : mag_d);
		end
	end

endmodule

FILE: rtl/core/ray_box_slab_intersection_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_core
// Slab test of a stream of rays against one axis-aligned box.
// ----------------------------------------------------------------------------
// The box corners are written through the cfg channel (index 0..5: low x, y,
// z, then high x, y, z; other indexes are ignored). cfg_ready is always high;
// write only while no item is in flight.
// Each ray item enters on the s_axis channel and its result leaves on the
// m_axis channel: tuser carries the hit flag, tdata the signed Q32.16
// distance, zero on a miss.
// The pipeline takes one item per cycle while the receiver does not stall;
// most of its depth is in the six 63-stage dividers of the slab parameters.
// The whole pipeline advances together: when the receiver stalls with a
// result waiting, s_axis_tready falls and every stage holds, so no item is
// lost or repeated. Reset clears all valid bits and the box to zero.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection_core import rbsi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, ray_length, zero pad
	input  logic [223:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// distance
	output logic [47:0]  m_axis_tdata,
	// hit
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic signed [31:0] box_low_q [3];
	logic signed [31:0] box_high_q [3];
	logic adv;

	assign cfg_ready = 1'b1;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_low_q[a]  <= '0;
				box_high_q[a] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOW_X:  box_low_q[0]  <= cfg_data;
				REG_LOW_Y:  box_low_q[1]  <= cfg_data;
				REG_LOW_Z:  box_low_q[2]  <= cfg_data;
				REG_HIGH_X: box_high_q[0] <= cfg_data;
				REG_HIGH_Y: box_high_q[1] <= cfg_data;
				REG_HIGH_Z: box_high_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: differences, magnitudes, the zero-direction and in-span tests.
	logic signed [31:0] org [3];
	logic signed [31:0] dir [3];
	logic [62:0] num_lo_s1 [3];
	logic [62:0] num_hi_s1 [3];
	logic [31:0] den_s1 [3];
	logic        neg_lo_s1 [3];
	logic        neg_hi_s1 [3];
	side_t       side_s1;
	logic [2:0]  dz_c, ins_c;
	logic signed [32:0] dlo [3];
	logic signed [32:0] dhi [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic signed [31:0] mn, mx;
			org[a] = s_axis_tdata[32*a +: 32];
			dir[a] = s_axis_tdata[96 + 32*a +: 32];
			dlo[a] = {box_low_q[a][31], box_low_q[a]} - {org[a][31], org[a]};
			dhi[a] = {box_high_q[a][31], box_high_q[a]} - {org[a][31], org[a]};
			mn = (box_low_q[a] < box_high_q[a]) ? box_low_q[a] : box_high_q[a];
			mx = (box_low_q[a] < box_high_q[a]) ? box_high_q[a] : box_low_q[a];
			dz_c[a]  = (dir[a] == 32'sd0);
			ins_c[a] = (org[a] >= mn) && (org[a] <= mx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (adv) begin
			side_s1.vld     <= s_axis_tvalid;
			side_s1.len     <= s_axis_tdata[222:192];
			side_s1.dzero   <= dz_c;
			side_s1.in_span <= ins_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				logic [32:0] mlo, mhi;
				mlo = dlo[a][32] ? 33'd0 - 33'(dlo[a]) : 33'(dlo[a]);
				mhi = dhi[a][32] ? 33'd0 - 33'(dhi[a]) : 33'(dhi[a]);
				num_lo_s1[a] <= {mlo[32:0], 30'd0};
				num_hi_s1[a] <= {mhi[32:0], 30'd0};
				den_s1[a]    <= dir[a][31] ? 32'd0 - 32'(dir[a]) : 32'(dir[a]);
				neg_lo_s1[a] <= dlo[a][32] ^ dir[a][31];
				neg_hi_s1[a] <= dhi[a][32] ^ dir[a][31];
			end
		end
	end

	// Dividers, with the control delayed alongside.
	logic signed [63:0] t_lo [3];
	logic signed [63:0] t_hi [3];
	side_t side_sd [DIV_LAT];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbsi_divider u_div_lo (
			.clk(clk), .en(adv), .num(num_lo_s1[a]), .den(den_s1[a]),
			.neg(neg_lo_s1[a]), .quot(t_lo[a])
		);
		rbsi_divider u_div_hi (
			.clk(clk), .en(adv), .num(num_hi_s1[a]), .den(den_s1[a]),
			.neg(neg_hi_s1[a]), .quot(t_hi[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) side_sd[k] <= '0;
		end else if (adv) begin
			side_sd[0] <= side_s1;
			for (int k = 1; k < DIV_LAT; k++) side_sd[k] <= side_sd[k-1];
		end
	end

	// Stages P1 to P3: per-axis entry and exit, box interval, hit and magnitude.
	logic signed [63:0] ent_p1 [3];
	logic signed [63:0] ext_p1 [3];
	logic        ok_p1, vld_p1, vld_p2, vld_p3;
	logic [30:0] len_p1, len_p2, len_p3;
	logic signed [63:0] tmin_p2, tmax_p2;
	logic        ok_p2, hit_p3, neg_p3;
	logic [63:0] mag_p3;
	side_t       sd;

	assign sd = side_sd[DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
		end else if (adv) begin
			vld_p1 <= sd.vld;
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [63:0] emax, lmin;
			logic okc;
			okc = 1'b1;
			for (int a = 0; a < 3; a++) begin
				if (sd.dzero[a]) begin
					ent_p1[a] <= SLAB_ALL_LOW;
					ext_p1[a] <= SLAB_ALL_HIGH;
					okc = okc & sd.in_span[a];
				end else begin
					ent_p1[a] <= (t_lo[a] < t_hi[a]) ? t_lo[a] : t_hi[a];
					ext_p1[a] <= (t_lo[a] < t_hi[a]) ? t_hi[a] : t_lo[a];
				end
			end
			ok_p1  <= okc;
			len_p1 <= sd.len;

			emax = ent_p1[0];
			lmin = ext_p1[0];
			for (int a = 1; a < 3; a++) begin
				if (ent_p1[a] > emax) emax = ent_p1[a];
				if (ext_p1[a] < lmin) lmin = ext_p1[a];
			end
			tmin_p2 <= emax;
			tmax_p2 <= lmin;
			ok_p2   <= ok_p1;
			len_p2  <= len_p1;

			hit_p3 <= ok_p2 && !tmax_p2[63] && !(tmin_p2 > tmax_p2);
			neg_p3 <= tmin_p2[63];
			mag_p3 <= tmin_p2[63] ? 64'd0 - 64'(tmin_p2) : 64'(tmin_p2);
			len_p3 <= len_p2;
		end
	end

	rbsi_scale u_scale (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.vld_in(vld_p3), .hit_in(hit_p3), .neg_in(neg_p3),
		.mag_in(mag_p3), .len_in(len_p3),
		.vld(m_axis_tvalid), .hit(m_axis_tuser), .distance(m_axis_tdata)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
		else $error("miss result carries a nonzero distance");

	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow the output stall");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |=> $stable(vld_p3) && $stable(side_s1.vld))
		else $error("pipeline moved during a stall");

endmodule
